FILE: rtl/kmpd_pkg.sv
// kmpd_pkg: shared types and constants for the keyboard/mouse packet decoder
// no dependencies; imported by every module of the decoder
package kmpd_pkg;

    typedef enum logic [1:0] {
        ACT_KEY_BYTE = 2'd0,
        ACT_SET_X    = 2'd1,
        ACT_SET_Y    = 2'd2,
        ACT_QUERY    = 2'd3
    } action_t;

    localparam logic [7:0]  MOUSE_HEADER_MIN = 8'd248;
    localparam logic [7:0]  BREAK_CODE_MIN   = 8'd128;
    localparam logic [31:0] POS_RESET        = 32'd128;
    localparam int          KEY_COUNT        = 128;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_Y     = 2'd1;
    localparam logic [1:0] PEND_X     = 2'd2;

    typedef struct packed {
        action_t     action;
        logic [7:0]  data_byte;
        logic [31:0] set_value;
    } kmpd_item_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic        left_button;
        logic        key_down;
    } kmpd_result_t;

endpackage

FILE: rtl/kmpd_in_stage.sv
// kmpd_in_stage: input register of the decoder, one word deep
// depends on kmpd_pkg for the item type
module kmpd_in_stage
    import kmpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  kmpd_item_t s_item,
    output logic       item_valid,
    input  logic       item_ready,
    output kmpd_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    kmpd_item_t item_reg;

    // free slot, or the held word leaves this cycle
    assign s_ready = !valid_reg || item_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/kmpd_core.sv
// kmpd_core: parser state, key map, mouse position and result register
// depends on kmpd_pkg for item/result types and decode constants
module kmpd_core
    import kmpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         item_valid,
    output logic         item_ready,
    input  kmpd_item_t   item,
    output logic         m_valid,
    input  logic         m_ready,
    output kmpd_result_t result
);

    logic [KEY_COUNT-1:0] key_map_reg;
    logic [KEY_COUNT-1:0] key_map_next;
    logic [1:0]           bytes_pending_reg;
    logic [1:0]           bytes_pending_next;
    logic [31:0]          mouse_x_reg;
    logic [31:0]          mouse_x_next;
    logic [31:0]          mouse_y_reg;
    logic [31:0]          mouse_y_next;
    logic [1:0]           buttons_reg;
    logic [1:0]           buttons_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    kmpd_result_t         result_reg;
    logic                 advance;
    logic [31:0]          delta;
    logic [6:0]           key_idx;

    assign item_ready = !m_valid_reg || m_ready;
    assign advance    = item_valid && item_ready;
    assign delta      = {{24{item.data_byte[7]}}, item.data_byte};
    assign key_idx    = item.data_byte[6:0];

    always_comb begin
        key_map_next       = key_map_reg;
        bytes_pending_next = bytes_pending_reg;
        mouse_x_next       = mouse_x_reg;
        mouse_y_next       = mouse_y_reg;
        buttons_next       = buttons_reg;
        if (advance) begin
            case (item.action)
                ACT_KEY_BYTE: begin
                    if (bytes_pending_reg == PEND_NONE) begin
                        if (item.data_byte >= MOUSE_HEADER_MIN) begin
                            buttons_next       = item.data_byte[1:0];
                            bytes_pending_next = PEND_X;
                        end else if (item.data_byte < BREAK_CODE_MIN) begin
                            key_map_next[key_idx] = 1'b1;
                        end else begin
                            key_map_next[key_idx] = 1'b0;
                        end
                    end else begin
                        if (bytes_pending_reg == PEND_Y) begin
                            mouse_y_next = mouse_y_reg + delta;
                        end else begin
                            mouse_x_next = mouse_x_reg + delta;
                        end
                        bytes_pending_next = bytes_pending_reg - 2'd1;
                    end
                end
                ACT_SET_X: begin
                    mouse_x_next = item.set_value;
                end
                ACT_SET_Y: begin
                    mouse_y_next = item.set_value;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_map_reg       <= '0;
            bytes_pending_reg <= PEND_NONE;
            mouse_x_reg       <= POS_RESET;
            mouse_y_reg       <= POS_RESET;
            buttons_reg       <= 2'd0;
            m_valid_reg       <= 1'b0;
        end else begin
            key_map_reg       <= key_map_next;
            bytes_pending_reg <= bytes_pending_next;
            mouse_x_reg       <= mouse_x_next;
            mouse_y_reg       <= mouse_y_next;
            buttons_reg       <= buttons_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg.pos_x       <= mouse_x_next;
            result_reg.pos_y       <= mouse_y_next;
            result_reg.left_button <= buttons_next[1];
            result_reg.key_down    <= key_map_next[key_idx];
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

`ifndef NO_ASSERTIONS
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && bytes_pending_reg == PEND_NONE)
        else $error("state not cleared by reset");

    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_pending_reg != 2'd3)
        else $error("packet byte count out of range");

    a_header_starts_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.action == ACT_KEY_BYTE && bytes_pending_reg == PEND_NONE
        && item.data_byte >= MOUSE_HEADER_MIN |=> bytes_pending_reg == PEND_X)
        else $error("mouse header did not open a packet");

    a_set_x_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.action == ACT_SET_X |=> result_reg.pos_x == $past(item.set_value))
        else $error("set x not reflected in result");

    a_query_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.action == ACT_QUERY |=>
        $stable(mouse_x_reg) && $stable(mouse_y_reg) && $stable(key_map_reg)
        && $stable(bytes_pending_reg))
        else $error("query changed decoder state");
`endif

endmodule

FILE: rtl/keyboard_mouse_packet_decoder_top.sv
// keyboard_mouse_packet_decoder_top: top level of the keyboard/mouse decoder
// depends on kmpd_pkg, kmpd_in_stage and kmpd_core
//
// Decodes the keyboard controller byte stream one word at a time and returns
// one result word per input word. Action 0 feeds a controller byte: outside a
// mouse packet, a byte of 248 or more opens a relative mouse packet (low two
// bits latch the buttons, the next two bytes are signed X then Y deltas, both
// positions wrap modulo 2^32); a byte below 128 presses that scan code in the
// 128-key map and 128..247 releases the key in its low seven bits. Actions 1
// and 2 load X or Y directly, action 3 only reads. Every result carries X, Y,
// the left button and the key map bit selected by data_byte[6:0] after the
// word is applied. Positions reset to 128, keys and buttons to zero. Rate: one
// word per cycle while m_ready stays high; an accepted word sits in the input
// register, then the combinational read-modify-write of parser state is
// written into the result register. Both stages hold their word under m_ready
// backpressure, and the input side keeps accepting as long as the result
// register can drain.
module keyboard_mouse_packet_decoder_top
    import kmpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_set_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pos_x,
    output logic [31:0] m_pos_y,
    output logic        m_left_button,
    output logic        m_key_down
);

    kmpd_item_t   s_item;
    kmpd_item_t   item;
    logic         item_valid;
    logic         item_ready;
    kmpd_result_t result;

    // pack the input ports into one word
    always_comb begin
        s_item.action    = action_t'(s_action);
        s_item.data_byte = s_data_byte;
        s_item.set_value = s_set_value;
    end

    // input register
    kmpd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // parser state update and result register
    kmpd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    // unpack the result word onto the ports
    assign m_pos_x       = result.pos_x;
    assign m_pos_y       = result.pos_y;
    assign m_left_button = result.left_button;
    assign m_key_down    = result.key_down;

endmodule
